[hw/rtl/sma_pkg.sv]
`default_nettype none
package sma_pkg;
	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DEPTH_OUT_W = 7;

	typedef enum logic [3:0] {
		K_CONST = 4'd0, K_ADD = 4'd1, K_SUB = 4'd2, K_MUL = 4'd3, K_DIV = 4'd4,
		K_MAX = 4'd5, K_MIN = 4'd6, K_NEG = 4'd7, K_DUP = 4'd8, K_SWAP = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FEW = 2'd1, ST_OVF = 2'd2, ST_DIV0 = 2'd3
	} status_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;     // capture request, start reads
		logic rd_b;     // read second entry
		logic alu;      // compute result into r_q
		logic div_go;   // start divider
		logic wr_r;     // write result at wr position
		logic wr_swap;  // second write for swap
		logic fin;      // update pointer, publish result
	} sma_cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_zero;
		logic is_div;
	} sma_sts_t;
endpackage
`default_nettype wire

[hw/rtl/sma_div.sv]
`default_nettype none
module sma_div import sma_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire logic [DATA_W-1:0] num,
	input  wire logic [DATA_W-1:0] den,
	output logic done,
	output logic [DATA_W-1:0] quo
);
	// restoring divider on magnitudes, one bit per cycle
	logic [DATA_W-1:0] q_q, d_q;
	logic [DATA_W:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q, neg_q;
	logic [DATA_W:0] trial;
	logic [DATA_W:0] shifted;

	assign shifted = {rem_q[DATA_W-1:0], q_q[DATA_W-1]};
	assign trial = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num[DATA_W-1] ? (~num + 1'b1) : num;
			d_q <= den[DATA_W-1] ? (~den + 1'b1) : den;
			rem_q <= '0;
			neg_q <= num[DATA_W-1] ^ den[DATA_W-1];
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial;
				q_q <= {q_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q <= {q_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? (~q_q + 1'b1) : q_q;
endmodule
`default_nettype wire

[hw/rtl/sma_dp.sv]
`default_nettype none
module sma_dp import sma_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned PW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sma_cmd_t cmd,
	output sma_sts_t sts,
	input  wire logic [3:0] in_kind,
	input  wire logic [DATA_W-1:0] in_operand,
	output logic [DATA_W-1:0] top_value,
	output logic [DEPTH_OUT_W-1:0] depth,
	output logic [1:0] status
);
	localparam int unsigned AW = $clog2(STACK_DEPTH);

	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_q, a_q, b_q, r_q, top_q;
	logic [PW-1:0] sp_q, nsp_q;
	logic [3:0] kind_q;
	logic [DATA_W-1:0] opnd_q;
	logic [1:0] st_q;
	logic [1:0] st_n_q;
	logic wr_en_q;
	logic [AW-1:0] rd_addr;
	logic [PW-1:0] rd_pos;
	logic [DATA_W-1:0] div_q;
	logic div_done;
	logic [DATA_W-1:0] prod;

	// shorthand for stack content (sp bounded by STACK_DEPTH)
	logic has1, has2, full;
	assign has1 = sp_q != '0;
	assign has2 = sp_q > PW'(1);
	assign full = sp_q == PW'(STACK_DEPTH);

	assign rd_pos = cmd.rd_b ? sp_q - PW'(2) : sp_q - PW'(1);
	assign rd_addr = rd_pos[AW-1:0];

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.wr_r)
			mem[nsp_q[AW-1:0] - AW'(1)] <= r_q;
		else if (cmd.wr_swap)
			mem[nsp_q[AW-1:0] - AW'(2)] <= a_q;
	end

	sma_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go),
		.num(a_q), .den(b_q), .done(div_done), .quo(div_q)
	);

	// only the low word of the product is kept
	assign prod = a_q * b_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			opnd_q <= in_operand;
		end
		if (cmd.rd_b)
			a_q <= has1 ? rd_q : '1;
		if (cmd.alu) begin
			b_q <= has2 ? rd_q : '1;
		end
	end

	// published result and next state, taken on fin; alu_d delays the alu command
	logic alu_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alu_d <= 1'b0;
			sp_q <= '0;
			top_q <= '0;
			st_q <= ST_OK;
		end else begin
			alu_d <= cmd.alu;
			if (cmd.fin) begin
				sp_q <= nsp_q;
				st_q <= st_n_q;
			end
			if (cmd.fin)
				top_q <= (nsp_q == '0) ? '0 : (wr_en_q ? r_q : top_q);
		end
	end

	// alu stage: compute r_q, nsp_q, status and whether top changes; on div_done, load the quotient into r_q
	always_ff @(posedge clk) begin
		if (alu_d) begin
			wr_en_q <= 1'b0;
			nsp_q <= sp_q;
			st_n_q <= ST_OK;
			r_q <= top_q;
			unique case (kind_q)
				K_CONST: begin
					if (full) st_n_q <= ST_OVF;
					else begin
						r_q <= opnd_q; nsp_q <= sp_q + PW'(1); wr_en_q <= 1'b1;
					end
				end
				K_ADD, K_SUB, K_MUL, K_MAX, K_MIN: begin
					wr_en_q <= 1'b1;
					nsp_q <= has2 ? sp_q - PW'(1) : PW'(1);
					case (kind_q)
						K_ADD: r_q <= a_q + b_q;
						K_SUB: r_q <= a_q - b_q;
						K_MUL: r_q <= prod;
						K_MAX: r_q <= ($signed(a_q) >= $signed(b_q)) ? a_q : b_q;
						default: r_q <= ($signed(a_q) <= $signed(b_q)) ? a_q : b_q;
					endcase
				end
				K_DIV: begin
					if (b_q == '0) st_n_q <= ST_DIV0;
					else begin
						wr_en_q <= 1'b1;
						nsp_q <= has2 ? sp_q - PW'(1) : PW'(1);
					end
				end
				K_NEG: begin
					wr_en_q <= 1'b1;
					r_q <= '0 - a_q;
					nsp_q <= has1 ? sp_q : PW'(1);
				end
				K_DUP: begin
					if (!has1) st_n_q <= ST_FEW;
					else if (full) st_n_q <= ST_OVF;
					else begin
						r_q <= a_q; nsp_q <= sp_q + PW'(1); wr_en_q <= 1'b1;
					end
				end
				K_SWAP: begin
					if (!has2) st_n_q <= ST_FEW;
					else begin
						r_q <= b_q; wr_en_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end else if (div_done) begin
			r_q <= div_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.div_zero = b_q == '0;
	assign sts.is_div = kind_q == K_DIV;

	assign top_value = top_q;
	assign depth = DEPTH_OUT_W'(sp_q);
	assign status = st_q;
endmodule
`default_nettype wire

[hw/rtl/sma_ctrl.sv]
`default_nettype none
module sma_ctrl import sma_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_fire,
	input  wire logic [3:0] kind,
	input  wire sma_sts_t sts,
	output sma_cmd_t cmd,
	output logic idle,
	output logic out_valid
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001, S_RDA = 9'b000000010, S_RDB = 9'b000000100,
		S_ALU = 9'b000001000, S_DEC = 9'b000010000, S_DIV = 9'b000100000,
		S_WR = 9'b001000000, S_WR2 = 9'b010000000, S_OUT = 9'b100000000
	} state_t;
	state_t state_q;
	logic swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			swap_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_RDA; swap_q <= kind == K_SWAP;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_ALU;
				S_ALU: state_q <= S_DEC;
				S_DEC: state_q <= (sts.is_div && !sts.div_zero) ? S_DIV : S_WR;
				S_DIV: if (sts.div_done) state_q <= S_WR;
				S_WR: state_q <= swap_q ? S_WR2 : S_OUT;
				S_WR2: state_q <= S_OUT;
				S_OUT: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.load = state_q == S_IDLE && in_fire;
		cmd.rd_b = state_q == S_RDA;
		cmd.alu = state_q == S_RDB;
		cmd.div_go = state_q == S_DEC && sts.is_div && !sts.div_zero;
		cmd.wr_r = state_q == S_WR;
		cmd.wr_swap = state_q == S_WR2;
		cmd.fin = (state_q == S_WR && !swap_q) || state_q == S_WR2;
	end
	assign idle = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;

	ap_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	ap_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |=> state_q == S_DIV) else $error("divider start lost");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_fire |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

[hw/rtl/stack_machine_alu_top.sv]
`default_nettype none
// Zero-operand 32-bit stack machine. Each request on s_axis is one instruction
// (kind, operand); one response per instruction on m_axis gives top of stack,
// depth and status. Requests are handled one at a time: a new request is
// taken only once the response to the last one has been taken. SWAP goes
// through a second write state, and a division waits in the divide state
// for the 32-step radix-2 divider. A stalled response holds the input off.
// The stack is a memory of STACK_DEPTH words with one read and one write
// port; its content is not reset, only the pointer.
module stack_machine_alu_top import sma_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // kind[3:0], operand[35:4], zero pad
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [47:0] m_axis_tdata        // top_value[31:0], depth[38:32], status[40:39]
);
	sma_cmd_t cmd;
	sma_sts_t sts;
	logic idle;
	logic [DATA_W-1:0] top_value;
	logic [DEPTH_OUT_W-1:0] depth;
	logic [1:0] status;

	assign s_axis_tready = idle;

	sma_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.out_fire(m_axis_tvalid && m_axis_tready),
		.kind(s_axis_tdata[3:0]), .sts(sts), .cmd(cmd),
		.idle(idle), .out_valid(m_axis_tvalid)
	);

	sma_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_kind(s_axis_tdata[3:0]), .in_operand(s_axis_tdata[35:4]),
		.top_value(top_value), .depth(depth), .status(status)
	);

	assign m_axis_tdata = {7'd0, status, depth, top_value};
endmodule
`default_nettype wire
